### sv/pfpid_pkg.sv
`timescale 1ns / 1ps

package pfpid_pkg;

   typedef enum logic [3:0] {
      OP_NONE,
      OP_QUAT,
      OP_ROTP,
      OP_ROTV,
      OP_NORM,
      OP_KP,
      OP_KD,
      OP_MASS,
      OP_KI,
      OP_AXA,
      OP_AXB
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [1:0] axis;
      logic [3:0] sel;
      logic       first;
      logic       last;
      logic       load;
   } cmd_type;

   // quaternion product slots, the last one squares the zone radius
   localparam logic [3:0] QIDX_RAD = 4'd9;

   // configuration register indexes
   localparam logic [2:0] REG_TPOS  = 3'd0;
   localparam logic [2:0] REG_TVEL  = 3'd1;
   localparam logic [2:0] REG_TACC  = 3'd2;
   localparam logic [2:0] REG_GAINS = 3'd3;
   localparam logic [2:0] REG_LIM   = 3'd4;

endpackage

### sv/position_force_pid_antiwindup.sv
`timescale 1ns / 1ps

// Position-loop force controller with back-calculation anti-windup.
// Request channel (req_*): one beat per control tick with measured position,
// velocity (Q8.8) and orientation quaternion (Q1.14).
// Response channel (rsp_*): one beat per request with the clamped body-frame
// force (Q16.8).
// Configuration channel (csr_*): register index and 64-bit data, always
// ready; write only while no tick is in flight.
// A new request beat is taken only once the previous tick has finished; the
// single shared 35x24 multiplier, issuing one product a cycle outside the
// gap states for the 43 products of a tick, paces the ticks.
// A response still waiting does not block the next request; its computation
// holds before writing the result registers until that beat is taken.
// Reset (synchronous) clears the configuration registers, the integrator and
// the windup terms, and drops rsp_valid.

module position_force_pid_antiwindup
   import pfpid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic signed [15:0] req_pos_x,
   input  logic signed [15:0] req_pos_y,
   input  logic signed [15:0] req_pos_z,
   input  logic signed [15:0] req_vel_x,
   input  logic signed [15:0] req_vel_y,
   input  logic signed [15:0] req_vel_z,
   input  logic signed [15:0] req_quat_w,
   input  logic signed [15:0] req_quat_x,
   input  logic signed [15:0] req_quat_y,
   input  logic signed [15:0] req_quat_z,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [23:0] rsp_force_x,
   output logic signed [23:0] rsp_force_y,
   output logic signed [23:0] rsp_force_z,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data
);

   cmd_type cmd;

   assign csr_ready = 1'b1;

   pfpid_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd)
   );

   pfpid_datapath u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .csr_valid (csr_valid),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .pos_z     (req_pos_z),
      .vel_x     (req_vel_x),
      .vel_y     (req_vel_y),
      .vel_z     (req_vel_z),
      .quat_w    (req_quat_w),
      .quat_x    (req_quat_x),
      .quat_y    (req_quat_y),
      .quat_z    (req_quat_z),
      .force_x   (rsp_force_x),
      .force_y   (rsp_force_y),
      .force_z   (rsp_force_z)
   );

endmodule

### sv/pfpid_controller.sv
`timescale 1ns / 1ps

module pfpid_controller
   import pfpid_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_QUAT,
      S_ROT,
      S_NORM,
      S_TERM,
      S_AXA,
      S_AXB,
      S_GAP,
      S_DONE
   } state_type;

   state_type  state_ff;
   state_type  after_ff;
   logic [1:0] i_ff;
   logic [3:0] j_ff;
   logic       k_ff;
   logic       gap_ff;
   logic       rsp_valid_ff;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd       = '0;
      cmd.op    = OP_NONE;
      cmd.axis  = i_ff;
      cmd.sel   = j_ff;
      cmd.load  = (state_ff == S_IDLE) && req_valid;
      unique case (state_ff)
         S_QUAT: cmd.op = OP_QUAT;
         S_ROT: begin
            cmd.op    = k_ff ? OP_ROTV : OP_ROTP;
            cmd.first = (j_ff == 4'd0);
            cmd.last  = (j_ff == 4'd2);
         end
         S_NORM: begin
            cmd.op    = OP_NORM;
            cmd.first = (i_ff == 2'd0);
            cmd.last  = (i_ff == 2'd2);
         end
         S_TERM: begin
            unique case (j_ff[1:0])
               2'd0: cmd.op = OP_KP;
               2'd1: cmd.op = OP_KD;
               2'd2: cmd.op = OP_MASS;
               2'd3: cmd.op = OP_KI;
            endcase
         end
         S_AXA: cmd.op = OP_AXA;
         S_AXB: cmd.op = OP_AXB;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         after_ff     <= S_IDLE;
         i_ff         <= 2'd0;
         j_ff         <= 4'd0;
         k_ff         <= 1'b0;
         gap_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_QUAT;
                  i_ff     <= 2'd0;
                  j_ff     <= 4'd0;
                  k_ff     <= 1'b0;
               end
            end
            S_QUAT: begin
               if (j_ff == QIDX_RAD) begin
                  j_ff     <= 4'd0;
                  state_ff <= S_GAP;
                  after_ff <= S_ROT;
                  gap_ff   <= 1'b1;
               end else begin
                  j_ff <= j_ff + 4'd1;
               end
            end
            S_ROT: begin
               if (j_ff == 4'd2) begin
                  j_ff <= 4'd0;
                  k_ff <= ~k_ff;
                  if (k_ff) begin
                     if (i_ff == 2'd2) begin
                        i_ff     <= 2'd0;
                        state_ff <= S_GAP;
                        after_ff <= S_NORM;
                        gap_ff   <= 1'b1;
                     end else begin
                        i_ff <= i_ff + 2'd1;
                     end
                  end
               end else begin
                  j_ff <= j_ff + 4'd1;
               end
            end
            S_NORM: begin
               if (i_ff == 2'd2) begin
                  i_ff     <= 2'd0;
                  state_ff <= S_GAP;
                  after_ff <= S_TERM;
                  gap_ff   <= 1'b1;
               end else begin
                  i_ff <= i_ff + 2'd1;
               end
            end
            S_TERM: begin
               if (j_ff == 4'd3) begin
                  j_ff <= 4'd0;
                  if (i_ff == 2'd2) begin
                     i_ff     <= 2'd0;
                     state_ff <= S_GAP;
                     after_ff <= S_AXA;
                     gap_ff   <= 1'b1;
                  end else begin
                     i_ff <= i_ff + 2'd1;
                  end
               end else begin
                  j_ff <= j_ff + 4'd1;
               end
            end
            S_AXA: begin
               if (i_ff == 2'd2) begin
                  i_ff     <= 2'd0;
                  state_ff <= S_GAP;
                  after_ff <= S_AXB;
                  gap_ff   <= 1'b1;
               end else begin
                  i_ff <= i_ff + 2'd1;
               end
            end
            S_AXB: begin
               if (i_ff == 2'd2) begin
                  i_ff     <= 2'd0;
                  state_ff <= S_GAP;
                  after_ff <= S_DONE;
                  gap_ff   <= 1'b1;
               end else begin
                  i_ff <= i_ff + 2'd1;
               end
            end
            S_GAP: begin
               if (gap_ff) begin
                  gap_ff <= 1'b0;
               end else if (after_ff != S_AXB || !rsp_valid_ff || rsp_ready) begin
                  // output beat must be gone before the result regs are rewritten
                  state_ff <= after_ff;
               end
            end
            S_DONE: begin
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

### sv/pfpid_datapath.sv
`timescale 1ns / 1ps

module pfpid_datapath
   import pfpid_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               csr_valid,
   input  logic [2:0]         csr_index,
   input  logic [63:0]        csr_data,
   input  logic signed [15:0] pos_x,
   input  logic signed [15:0] pos_y,
   input  logic signed [15:0] pos_z,
   input  logic signed [15:0] vel_x,
   input  logic signed [15:0] vel_y,
   input  logic signed [15:0] vel_z,
   input  logic signed [15:0] quat_w,
   input  logic signed [15:0] quat_x,
   input  logic signed [15:0] quat_y,
   input  logic signed [15:0] quat_z,
   output logic signed [23:0] force_x,
   output logic signed [23:0] force_y,
   output logic signed [23:0] force_z
);

   localparam logic signed [34:0] ONE    = 35'sd268435456;
   localparam logic signed [52:0] HALF27 = 53'sd134217728;
   localparam logic signed [34:0] W_MAX  = 35'sd2147483647;
   localparam logic signed [34:0] W_MIN  = -35'sd2147483648;

   function automatic logic signed [34:0] clamp_mag(input logic signed [34:0] v,
                                                    input logic [15:0] lim);
      logic signed [34:0] l;
      l = $signed({19'b0, lim});
      if (v > l) return l;
      if (v < -l) return -l;
      return v;
   endfunction

   logic [47:0] tpos_ff;
   logic [47:0] tvel_ff;
   logic [47:0] tacc_ff;
   logic [63:0] gains_ff;
   logic [47:0] lim_ff;

   logic signed [16:0] ep_w_ff [3];
   logic signed [16:0] ev_w_ff [3];
   logic signed [15:0] q_ff    [4];
   logic signed [31:0] p_ff    [9];
   logic [31:0]        rad2_ff;
   logic signed [34:0] r_ff    [3][3];
   logic signed [58:0] prod_ff;
   cmd_type            cmd_d_ff;
   logic signed [52:0] acc_ff;
   logic signed [23:0] ep_b_ff [3];
   logic signed [23:0] ev_b_ff [3];
   logic               active_ff;
   logic signed [33:0] tot_ff  [3];
   logic signed [33:0] kit_ff  [3];
   logic signed [23:0] integ_ff [3];
   logic signed [31:0] wind_ff [3];
   logic signed [23:0] force_ff [3];

   logic [15:0] kp, kd, ki, mass, radius, ilim, flim;
   assign kp     = gains_ff[15:0];
   assign kd     = gains_ff[31:16];
   assign ki     = gains_ff[47:32];
   assign mass   = gains_ff[63:48];
   assign radius = lim_ff[15:0];
   assign ilim   = lim_ff[31:16];
   assign flim   = lim_ff[47:32];

   logic signed [15:0] tacc [3];
   assign tacc[0] = $signed(tacc_ff[15:0]);
   assign tacc[1] = $signed(tacc_ff[31:16]);
   assign tacc[2] = $signed(tacc_ff[47:32]);

   always_ff @(posedge clock) begin
      if (reset) begin
         tpos_ff  <= '0;
         tvel_ff  <= '0;
         tacc_ff  <= '0;
         gains_ff <= '0;
         lim_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_TPOS:  tpos_ff  <= csr_data[47:0];
            REG_TVEL:  tvel_ff  <= csr_data[47:0];
            REG_TACC:  tacc_ff  <= csr_data[47:0];
            REG_GAINS: gains_ff <= csr_data;
            REG_LIM:   lim_ff   <= csr_data[47:0];
            default: ;
         endcase
      end
   end

   // input capture and world-frame errors
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         q_ff[0]    <= quat_w;
         q_ff[1]    <= quat_x;
         q_ff[2]    <= quat_y;
         q_ff[3]    <= quat_z;
         ep_w_ff[0] <= {tpos_ff[15], tpos_ff[15:0]} - {pos_x[15], pos_x};
         ep_w_ff[1] <= {tpos_ff[31], tpos_ff[31:16]} - {pos_y[15], pos_y};
         ep_w_ff[2] <= {tpos_ff[47], tpos_ff[47:32]} - {pos_z[15], pos_z};
         ev_w_ff[0] <= {tvel_ff[15], tvel_ff[15:0]} - {vel_x[15], vel_x};
         ev_w_ff[1] <= {tvel_ff[31], tvel_ff[31:16]} - {vel_y[15], vel_y};
         ev_w_ff[2] <= {tvel_ff[47], tvel_ff[47:32]} - {vel_z[15], vel_z};
      end
   end

   // rotation matrix from the quaternion products
   always_ff @(posedge clock) begin
      r_ff[0][0] <= ONE - ((35'(p_ff[1]) + 35'(p_ff[2])) <<< 1);
      r_ff[0][1] <= (35'(p_ff[3]) - 35'(p_ff[8])) <<< 1;
      r_ff[0][2] <= (35'(p_ff[4]) + 35'(p_ff[7])) <<< 1;
      r_ff[1][0] <= (35'(p_ff[3]) + 35'(p_ff[8])) <<< 1;
      r_ff[1][1] <= ONE - ((35'(p_ff[0]) + 35'(p_ff[2])) <<< 1);
      r_ff[1][2] <= (35'(p_ff[5]) - 35'(p_ff[6])) <<< 1;
      r_ff[2][0] <= (35'(p_ff[4]) - 35'(p_ff[7])) <<< 1;
      r_ff[2][1] <= (35'(p_ff[5]) + 35'(p_ff[6])) <<< 1;
      r_ff[2][2] <= ONE - ((35'(p_ff[0]) + 35'(p_ff[1])) <<< 1);
   end

   logic [1:0]         qa, qb;
   logic signed [34:0] a_w;
   logic signed [23:0] b_w;

   always_comb begin
      unique case (cmd.sel)
         4'd0:    begin qa = 2'd1; qb = 2'd1; end
         4'd1:    begin qa = 2'd2; qb = 2'd2; end
         4'd2:    begin qa = 2'd3; qb = 2'd3; end
         4'd3:    begin qa = 2'd1; qb = 2'd2; end
         4'd4:    begin qa = 2'd1; qb = 2'd3; end
         4'd5:    begin qa = 2'd2; qb = 2'd3; end
         4'd6:    begin qa = 2'd0; qb = 2'd1; end
         4'd7:    begin qa = 2'd0; qb = 2'd2; end
         4'd8:    begin qa = 2'd0; qb = 2'd3; end
         default: begin qa = 2'd0; qb = 2'd0; end
      endcase
   end

   always_comb begin
      a_w = '0;
      b_w = '0;
      unique case (cmd.op)
         OP_QUAT: begin
            if (cmd.sel == QIDX_RAD) begin
               a_w = $signed({19'b0, radius});
               b_w = $signed({8'b0, radius});
            end else begin
               a_w = 35'(q_ff[qa]);
               b_w = 24'(q_ff[qb]);
            end
         end
         OP_ROTP: begin
            a_w = r_ff[cmd.sel[1:0]][cmd.axis];
            b_w = 24'(ep_w_ff[cmd.sel[1:0]]);
         end
         OP_ROTV: begin
            a_w = r_ff[cmd.sel[1:0]][cmd.axis];
            b_w = 24'(ev_w_ff[cmd.sel[1:0]]);
         end
         OP_NORM: begin
            a_w = 35'(ep_b_ff[cmd.axis]);
            b_w = ep_b_ff[cmd.axis];
         end
         OP_KP: begin
            a_w = 35'(ep_b_ff[cmd.axis]);
            b_w = $signed({8'b0, kp});
         end
         OP_KD: begin
            a_w = 35'(ev_b_ff[cmd.axis]);
            b_w = $signed({8'b0, kd});
         end
         OP_MASS: begin
            a_w = 35'(tacc[cmd.axis]);
            b_w = $signed({8'b0, mass});
         end
         OP_KI: begin
            a_w = 35'(ep_b_ff[cmd.axis]);
            b_w = $signed({8'b0, ki});
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= a_w * b_w;
      if (reset) begin
         cmd_d_ff <= '0;
      end else begin
         cmd_d_ff <= cmd;
      end
   end

   logic [1:0]         ax;
   logic signed [52:0] acc_sum;
   logic signed [58:0] rnd;
   logic signed [33:0] r8;
   logic signed [34:0] s_int, int_new, total, force_c, wind_d, wind_sat;

   always_comb begin
      ax      = cmd_d_ff.axis;
      acc_sum = acc_ff + 53'(prod_ff);
      rnd     = prod_ff + 59'sd128;
      r8      = rnd[41:8];
      s_int   = 35'(integ_ff[ax]) + 35'(kit_ff[ax]) + 35'(wind_ff[ax]);
      int_new = active_ff ? clamp_mag(s_int, ilim) : '0;
      total   = 35'(tot_ff[ax]) + 35'(integ_ff[ax]);
      force_c = clamp_mag(total, flim);
      wind_d  = force_c - total;
      if (wind_d > W_MAX) begin
         wind_sat = W_MAX;
      end else if (wind_d < W_MIN) begin
         wind_sat = W_MIN;
      end else begin
         wind_sat = wind_d;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int n = 0; n < 3; n++) begin
            integ_ff[n] <= '0;
            wind_ff[n]  <= '0;
         end
      end else begin
         unique case (cmd_d_ff.op)
            OP_QUAT: begin
               if (cmd_d_ff.sel == QIDX_RAD) begin
                  rad2_ff <= prod_ff[31:0];
               end else begin
                  p_ff[cmd_d_ff.sel] <= prod_ff[31:0];
               end
            end
            OP_ROTP, OP_ROTV: begin
               if (cmd_d_ff.first) begin
                  acc_ff <= 53'(prod_ff) + HALF27;
               end else begin
                  acc_ff <= acc_sum;
               end
               if (cmd_d_ff.last && cmd_d_ff.op == OP_ROTP) begin
                  ep_b_ff[ax] <= acc_sum[51:28];
               end
               if (cmd_d_ff.last && cmd_d_ff.op == OP_ROTV) begin
                  ev_b_ff[ax] <= acc_sum[51:28];
               end
            end
            OP_NORM: begin
               if (cmd_d_ff.first) begin
                  acc_ff <= 53'(prod_ff);
               end else begin
                  acc_ff <= acc_sum;
               end
               if (cmd_d_ff.last) begin
                  active_ff <= acc_sum < $signed({21'b0, rad2_ff});
               end
            end
            OP_KP:   tot_ff[ax] <= r8;
            OP_KD:   tot_ff[ax] <= tot_ff[ax] + r8;
            OP_MASS: tot_ff[ax] <= tot_ff[ax] + r8;
            OP_KI:   kit_ff[ax] <= r8;
            OP_AXA:  integ_ff[ax] <= int_new[23:0];
            OP_AXB: begin
               wind_ff[ax]  <= wind_sat[31:0];
               force_ff[ax] <= force_c[23:0];
            end
            default: ;
         endcase
      end
   end

   assign force_x = force_ff[0];
   assign force_y = force_ff[1];
   assign force_z = force_ff[2];

endmodule

### sv/pfpid_checker.sv
`timescale 1ns / 1ps

module pfpid_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [23:0] rsp_force_x,
   input logic signed [23:0] rsp_force_y,
   input logic signed [23:0] rsp_force_z,
   input logic               csr_ready
);

   // stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x)
         && $stable(rsp_force_y) && $stable(rsp_force_z))
      else $error("stalled response beat changed");

   // busy after taking a request beat
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   // no result right after a request
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !$rose(rsp_valid))
      else $error("response too early");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("config port not ready");

endmodule

bind position_force_pid_antiwindup pfpid_checker u_chk (.*);

### tb/tb_position_force_pid_antiwindup.sv
`timescale 1ns / 1ps

module tb_position_force_pid_antiwindup
   import pfpid_pkg::*;
();

   localparam logic [2:0] REG_BAD = 3'd7;
   localparam logic [63:0] DIR_TPOS = 64'h0000_0100_FF00_0080;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int N_RANDOM = 1800;

   typedef struct {
      logic signed [15:0] pos [3];
      logic signed [15:0] vel [3];
      logic signed [15:0] quat [4];
   } tick_type;

   typedef struct {
      logic signed [23:0] f [3];
   } force_type;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   logic signed [15:0] req_pos_x, req_pos_y, req_pos_z;
   logic signed [15:0] req_vel_x, req_vel_y, req_vel_z;
   logic signed [15:0] req_quat_w, req_quat_x, req_quat_y, req_quat_z;
   logic rsp_valid;
   logic rsp_ready;
   logic signed [23:0] rsp_force_x, rsp_force_y, rsp_force_z;
   logic csr_valid;
   logic csr_ready;
   logic [2:0] csr_index;
   logic [63:0] csr_data;

   position_force_pid_antiwindup dut (.*);

   // shadow of the controller state
   logic [63:0] sh_tpos, sh_tvel, sh_tacc, sh_gains, sh_limits;
   longint integ [3];
   longint windup [3];

   force_type expected_forces [$];
   force_type zero_force;
   int mismatches = 0;
   int idle_cycles = 0;
   int stall_cnt = 0;
   bit timed_out = 0;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   function automatic longint half_s(logic [63:0] r, int i);
      logic signed [15:0] h;
      h = r[16*i +: 16];
      return longint'(h);
   endfunction

   function automatic longint half_u(logic [63:0] r, int i);
      return longint'(r[16*i +: 16]);
   endfunction

   function automatic longint rnd_shift(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint clamp_mag(longint v, longint lim);
      if (v > lim) return lim;
      if (v < -lim) return -lim;
      return v;
   endfunction

   function automatic void shadow_csr_write(logic [2:0] idx, logic [63:0] d);
      case (idx)
         REG_TPOS: sh_tpos = {16'd0, d[47:0]};
         REG_TVEL: sh_tvel = {16'd0, d[47:0]};
         REG_TACC: sh_tacc = {16'd0, d[47:0]};
         REG_GAINS: sh_gains = d;
         REG_LIM: sh_limits = {16'd0, d[47:0]};
         default: ;
      endcase
   endfunction

   function automatic force_type predict_force(tick_type t);
      longint w, x, y, z, one, norm2, radius, s, total, fo, wd, acc;
      longint rm [3][3];
      longint epw [3], evw [3], epb [3], evb [3];
      longint sp, sv, prop, deriv;
      bit active;
      force_type r;
      w = t.quat[0]; x = t.quat[1]; y = t.quat[2]; z = t.quat[3];
      one = longint'(1) <<< 28;
      rm[0][0] = one - 2 * (y * y + z * z);
      rm[0][1] = 2 * (x * y - w * z);
      rm[0][2] = 2 * (x * z + w * y);
      rm[1][0] = 2 * (x * y + w * z);
      rm[1][1] = one - 2 * (x * x + z * z);
      rm[1][2] = 2 * (y * z - w * x);
      rm[2][0] = 2 * (x * z - w * y);
      rm[2][1] = 2 * (y * z + w * x);
      rm[2][2] = one - 2 * (x * x + y * y);
      norm2 = 0;
      for (int i = 0; i < 3; i++) begin
         epw[i] = half_s(sh_tpos, i) - longint'(t.pos[i]);
         evw[i] = half_s(sh_tvel, i) - longint'(t.vel[i]);
      end
      for (int i = 0; i < 3; i++) begin
         sp = 0;
         sv = 0;
         for (int j = 0; j < 3; j++) begin
            sp += rm[j][i] * epw[j];
            sv += rm[j][i] * evw[j];
         end
         epb[i] = rnd_shift(sp, 28);
         evb[i] = rnd_shift(sv, 28);
         norm2 += epb[i] * epb[i];
      end
      radius = half_u(sh_limits, 0);
      active = norm2 < radius * radius;
      for (int i = 0; i < 3; i++) begin
         acc = half_s(sh_tacc, i);
         prop = rnd_shift(half_u(sh_gains, 0) * epb[i], 8);
         deriv = rnd_shift(half_u(sh_gains, 1) * evb[i], 8)
               + rnd_shift(half_u(sh_gains, 3) * acc, 8);
         if (active) begin
            s = integ[i] + rnd_shift(half_u(sh_gains, 2) * epb[i], 8) + windup[i];
            integ[i] = clamp_mag(s, half_u(sh_limits, 1));
         end else begin
            integ[i] = 0;
         end
         total = prop + deriv + integ[i];
         fo = clamp_mag(total, half_u(sh_limits, 2));
         wd = fo - total;
         if (wd > 64'sd2147483647) wd = 64'sd2147483647;
         if (wd < -64'sd2147483648) wd = -64'sd2147483648;
         windup[i] = wd;
         r.f[i] = fo[23:0];
      end
      return r;
   endfunction

   task automatic csr_write(logic [2:0] idx, logic [63:0] d);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      shadow_csr_write(idx, d);
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (expected_forces.size() != 0) @(posedge clock);
      repeat (70) @(posedge clock);
   endtask

   task automatic random_gap();
      int g;
      g = $urandom_range(0, 99);
      if (g < 40) return;
      if (g < 95) repeat ($urandom_range(1, 4)) @(posedge clock);
      else repeat ($urandom_range(20, 150)) @(posedge clock);
   endtask

   task automatic send_tick(tick_type t, bit typed, force_type want);
      force_type p;
      req_valid <= 1'b1;
      req_pos_x <= t.pos[0]; req_pos_y <= t.pos[1]; req_pos_z <= t.pos[2];
      req_vel_x <= t.vel[0]; req_vel_y <= t.vel[1]; req_vel_z <= t.vel[2];
      req_quat_w <= t.quat[0]; req_quat_x <= t.quat[1];
      req_quat_y <= t.quat[2]; req_quat_z <= t.quat[3];
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      p = predict_force(t);
      expected_forces.push_back(typed ? want : p);
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic signed [15:0] rand_q();
      int c;
      c = $urandom_range(0, 9);
      if (c == 0) return 16'sd16384;
      if (c == 1) return -16'sd16384;
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic tick_type rand_tick(bit near);
      tick_type t;
      for (int i = 0; i < 3; i++) begin
         if (near) begin
            t.pos[i] = 16'(half_s(sh_tpos, i) + longint'($urandom_range(0, 1024)) - 512);
            t.vel[i] = 16'(half_s(sh_tvel, i) + longint'($urandom_range(0, 1024)) - 512);
         end else begin
            t.pos[i] = 16'($urandom);
            t.vel[i] = 16'($urandom);
         end
      end
      if ($urandom_range(0, 3) == 0) begin
         t.quat[0] = 16'sd16384; t.quat[1] = 0; t.quat[2] = 0; t.quat[3] = 0;
      end else begin
         for (int k = 0; k < 4; k++) t.quat[k] = rand_q();
      end
      return t;
   endfunction

   task automatic random_config(int mode);
      csr_write(REG_TPOS, {$urandom, $urandom});
      csr_write(REG_TVEL, {$urandom, $urandom});
      csr_write(REG_TACC, {$urandom, $urandom});
      if (mode == 0) begin
         csr_write(REG_GAINS, {$urandom, $urandom});
         csr_write(REG_LIM, {$urandom, $urandom});
      end else if (mode == 1) begin
         csr_write(REG_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
         csr_write(REG_LIM, 64'h0000_FFFF_FFFF_FFFF);
      end else begin
         csr_write(REG_GAINS, {16'($urandom_range(0, 1024)), 16'($urandom_range(0, 512)),
                               16'($urandom_range(0, 512)), 16'($urandom_range(0, 1024))});
         csr_write(REG_LIM, {16'd0, 16'($urandom_range(256, 8000)),
                             16'($urandom_range(256, 4000)),
                             16'($urandom_range(256, 4000))});
      end
   endtask

   // response side
   always @(posedge clock) begin
      force_type e;
      logic signed [23:0] got [3];
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_cnt <= 0;
      end else begin
         if (stall_cnt != 0) begin
            stall_cnt <= stall_cnt - 1;
            rsp_ready <= 1'b0;
         end else if ($urandom_range(0, 99) < 2) begin
            stall_cnt <= $urandom_range(20, 150);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 3) != 0);
         end
         if (rsp_valid && rsp_ready) begin
            got[0] = rsp_force_x; got[1] = rsp_force_y; got[2] = rsp_force_z;
            if (expected_forces.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected force beat %0d %0d %0d", got[0], got[1], got[2]);
            end else begin
               e = expected_forces.pop_front();
               for (int i = 0; i < 3; i++)
                  if (got[i] !== e.f[i]) begin
                     mismatches++;
                     if (mismatches <= 10)
                        $display("force axis %0d: expected %0d, got %0d",
                                 i, e.f[i], got[i]);
                  end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (csr_valid && csr_ready)
          || (req_valid == 0 && expected_forces.size() == 0))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
         timed_out = 1;
         $display("status: fail");
         $finish;
      end
   end

   tick_type dir_ticks [$];
   bit dir_typed [$];

   initial begin
      tick_type t;
      reset = 1'b1;
      req_valid = 1'b0; csr_valid = 1'b0; csr_index = '0; csr_data = '0;
      req_pos_x = 0; req_pos_y = 0; req_pos_z = 0;
      req_vel_x = 0; req_vel_y = 0; req_vel_z = 0;
      req_quat_w = 0; req_quat_x = 0; req_quat_y = 0; req_quat_z = 0;
      sh_tpos = 0; sh_tvel = 0; sh_tacc = 0; sh_gains = 0; sh_limits = 0;
      for (int i = 0; i < 3; i++) begin
         integ[i] = 0;
         windup[i] = 0;
         zero_force.f[i] = 24'sd0;
      end

      // after reset all gains and limits are zero: force is zero
      t.pos = '{16'sh7FFF, 16'sh8000, 16'sd0};
      t.vel = '{16'sh8000, 16'sh7FFF, 16'sd1};
      t.quat = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
      dir_ticks.push_back(t);
      dir_typed.push_back(1'b1);

      // extremes, clamps, zone edges, odd quaternions
      for (int n = 0; n < 22; n++) begin
         case (n % 6)
            0: t.quat = '{16'sd16384, 16'sd0, 16'sd0, 16'sd0};
            1: t.quat = '{-16'sd16384, 16'sd16384, -16'sd16384, 16'sd16384};
            2: t.quat = '{16'sd0, 16'sd16384, 16'sd0, 16'sd0};
            3: t.quat = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd16384};
            4: t.quat = '{-16'sd16384, -16'sd16384, -16'sd16384, -16'sd16384};
            default: t.quat = '{16'sd0, 16'sd0, 16'sd0, -16'sd16384};
         endcase
         for (int i = 0; i < 3; i++) begin
            t.pos[i] = (n % 3 == 0) ? 16'sh7FFF : (n % 3 == 1) ? 16'sh8000
                     : DIR_TPOS[16*i +: 16];
            t.vel[i] = (n % 2 != 0) ? 16'sh7FFF : 16'sh8000;
         end
         dir_ticks.push_back(t);
         // zero force limit: force is zero
         dir_typed.push_back(n >= 10 && n <= 14);
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int r = 0; r < dir_ticks.size(); r++) begin
         if (r == 1) begin
            wait_drained();
            csr_write(REG_TPOS, DIR_TPOS);
            csr_write(REG_TVEL, 64'h0000_8000_7FFF_0000);
            csr_write(REG_TACC, 64'h0000_7FFF_8000_0100);
            csr_write(REG_GAINS, 64'hFFFF_FFFF_FFFF_FFFF);
            csr_write(REG_LIM, 64'h0000_FFFF_FFFF_FFFF);
            csr_write(REG_BAD, 64'hFFFF_FFFF_FFFF_FFFF);
         end else if (r == 11) begin
            wait_drained();
            csr_write(REG_LIM, 64'h0000_0000_0000_0000);
         end else if (r == 16) begin
            wait_drained();
            csr_write(REG_LIM, 64'h0000_0100_0080_FFFF);
            csr_write(REG_GAINS, 64'h0100_0200_FFFF_0400);
         end
         send_tick(dir_ticks[r], dir_typed[r], zero_force);
         random_gap();
      end

      // random part, reconfigured in phases
      for (int n = 0; n < N_RANDOM; n++) begin
         if (n % 300 == 0) begin
            wait_drained();
            random_config((n / 300) % 3);
         end
         send_tick(rand_tick($urandom_range(0, 3) != 0), 1'b0, zero_force);
         if (n == 900) begin
            while (expected_forces.size() != 0) @(posedge clock);
         end else begin
            random_gap();
         end
      end

      wait_drained();
      if (mismatches == 0 && expected_forces.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
